// ----- hdl/bsa_pkg.sv -----
package bsa_pkg;

  // Field widths of the request and result transactions
  localparam int unsigned ACTION_W       = 2;
  localparam int unsigned ITEM_WEIGHT_W  = 16;
  localparam int unsigned SLOT_INDEX_W   = 6;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned GRANTED_SLOT_W = 6;
  localparam int unsigned TOTAL_WEIGHT_W = 22;
  localparam int unsigned ENTRY_COUNT_W  = 7;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 22;
  localparam int unsigned LIMIT_W     = 22;

  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_LIMIT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_ENABLED = 2'd1;

  // Default sizes
  localparam int unsigned DEF_SLOT_COUNT  = 64;
  localparam int unsigned DEF_WEIGHT_BITS = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

endpackage

// ----- hdl/bsa_free_search.sv -----
module bsa_free_search #(
  parameter int unsigned SLOT_COUNT = bsa_pkg::DEF_SLOT_COUNT,
  parameter int unsigned IDX_W      = $clog2(SLOT_COUNT)
) (
  input  logic [SLOT_COUNT-1:0] used_i,
  output logic                  found_o,
  output logic [IDX_W-1:0]      free_idx_o
);
  import bsa_pkg::*;

  // Lowest free slot wins: scan from the top so the lowest hit is last.
  always_comb begin
    found_o    = 1'b0;
    free_idx_o = '0;
    for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
      if (!used_i[k]) begin
        found_o    = 1'b1;
        free_idx_o = IDX_W'(k);
      end
    end
  end

endmodule

// ----- hdl/bsa_weight_store.sv -----
module bsa_weight_store #(
  parameter int unsigned DEPTH  = bsa_pkg::DEF_SLOT_COUNT,
  parameter int unsigned DATA_W = bsa_pkg::DEF_WEIGHT_BITS,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);
  import bsa_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read; a same-cycle write to the read address is forwarded.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/budgeted_slot_allocator_unit.sv -----
// Budgeted first-fit slot allocator.
//
// Request channel (in_valid_i / in_stall_o): action, item weight, slot index.
// Add takes the lowest free slot unless the enabled weight limit would be
// exceeded; remove frees one slot and subtracts its weight; clear empties
// the store. Result channel (out_valid_o / out_stall_i): status, slot,
// total weight and entry count after the step, one result per request.
// Config channel (cfg_valid_i / cfg_ready_o) writes weight_limit (index 0)
// and limit_enabled (index 1); ready is always high, other indexes ignored.
//
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the result stage that updates slot marks, total and count in the
// same cycle it decides status. The slot weight memory is read at accept
// time, so its registered data meets the request in the result stage.
//
// Reset clears all slot marks, the total, the count and both config
// registers; no clearing pass is needed. When the receiver stalls the
// result register holds, the request register still takes one more item,
// and then in_stall_o rises until the result is taken.
module budgeted_slot_allocator_unit #(
  parameter int unsigned SLOT_COUNT  = bsa_pkg::DEF_SLOT_COUNT,
  parameter int unsigned WEIGHT_BITS = bsa_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bsa_pkg::ACTION_W-1:0]        action_i,
  input  logic [bsa_pkg::ITEM_WEIGHT_W-1:0]   item_weight_i,
  input  logic [bsa_pkg::SLOT_INDEX_W-1:0]    slot_index_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bsa_pkg::STATUS_W-1:0]        status_o,
  output logic [bsa_pkg::GRANTED_SLOT_W-1:0]  granted_slot_o,
  output logic [bsa_pkg::TOTAL_WEIGHT_W-1:0]  total_weight_o,
  output logic [bsa_pkg::ENTRY_COUNT_W-1:0]   entry_count_o,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bsa_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import bsa_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  // Holds SLOT_COUNT full weights plus one more without overflow
  localparam int unsigned SUM_W = WEIGHT_BITS + CNT_W;
  localparam int unsigned CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

  // ---------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------
  logic [LIMIT_W-1:0] limit_q;
  logic               lim_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= '0;
      lim_en_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WEIGHT_LIMIT:  limit_q  <= LIMIT_W'(cfg_data_i);
        CFG_LIMIT_ENABLED: lim_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------
  logic in_vld_q;
  logic out_vld_q;
  logic fire;
  logic accept;

  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Request register
  // ---------------------------------------------------------------
  action_e                   act_q;
  logic [WEIGHT_BITS-1:0]    w_q;
  logic [SLOT_INDEX_W-1:0]   idx_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_e'(action_i);
      w_q   <= WEIGHT_BITS'(item_weight_i);
      idx_q <= slot_index_i;
    end
  end

  // ---------------------------------------------------------------
  // Slot state
  // ---------------------------------------------------------------
  logic [SLOT_COUNT-1:0]  used_q, used_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic                   found;
  logic [IDX_W-1:0]       free_idx;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic                   mem_we;

  bsa_free_search #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_search (
    .used_i     (used_q),
    .found_o    (found),
    .free_idx_o (free_idx)
  );

  bsa_weight_store #(
    .DEPTH     (SLOT_COUNT),
    .DATA_W    (WEIGHT_BITS),
    .ADDR_W    (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (IDX_W'(slot_index_i)),
    .rd_data_o (rd_weight),
    .wr_en_i   (mem_we),
    .wr_addr_i (free_idx),
    .wr_data_i (w_q)
  );

  // ---------------------------------------------------------------
  // Result stage
  // ---------------------------------------------------------------
  logic [IDX_W-1:0]          rm_idx;
  logic                      in_range;
  logic                      over;
  status_e                   res_status;
  logic [GRANTED_SLOT_W-1:0] res_slot;

  assign rm_idx   = IDX_W'(idx_q);
  assign in_range = (32'(idx_q) < 32'(SLOT_COUNT));
  assign over     = lim_en_q &&
                    ((CMP_W'(sum_q) + CMP_W'(w_q)) > CMP_W'(limit_q));

  always_comb begin
    used_d     = used_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    res_status = ST_OK;
    res_slot   = '0;
    mem_we     = 1'b0;
    case (act_q)
      ACT_ADD: begin
        if (over) begin
          res_status = ST_OVER;
        end else if (!found) begin
          res_status = ST_FULL;
        end else begin
          used_d[free_idx] = 1'b1;
          sum_d            = sum_q + SUM_W'(w_q);
          cnt_d            = cnt_q + CNT_W'(1);
          res_slot         = GRANTED_SLOT_W'(free_idx);
          mem_we           = fire;
        end
      end
      ACT_REMOVE: begin
        res_slot = GRANTED_SLOT_W'(idx_q);
        if (in_range && used_q[rm_idx]) begin
          used_d[rm_idx] = 1'b0;
          sum_d          = sum_q - SUM_W'(rd_weight);
          cnt_d          = cnt_q - CNT_W'(1);
        end else begin
          res_status = ST_EMPTY;
        end
      end
      ACT_CLEAR: begin
        used_d = '0;
        sum_d  = '0;
        cnt_d  = '0;
      end
      default: ;  // unused code: no change
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
    end else if (fire) begin
      used_q <= used_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic [STATUS_W-1:0]       status_q;
  logic [GRANTED_SLOT_W-1:0] slot_q;
  logic [TOTAL_WEIGHT_W-1:0] total_q;
  logic [ENTRY_COUNT_W-1:0]  count_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= res_status;
      slot_q   <= res_slot;
      total_q  <= TOTAL_WEIGHT_W'(sum_d);
      count_q  <= ENTRY_COUNT_W'(cnt_d);
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = status_q;
  assign granted_slot_o = slot_q;
  assign total_weight_o = total_q;
  assign entry_count_o  = count_q;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_count_matches_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == 32'(cnt_q))
    else $error("entry count disagrees with slot marks");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(SLOT_COUNT))
    else $error("entry count above slot count");

  a_write_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (found && !used_q[free_idx]))
    else $error("weight written to an occupied slot");

  a_over_needs_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (res_status == ST_OVER)) |-> lim_en_q)
    else $error("over-limit status while limit disabled");

  a_mark_set_after_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> used_q[$past(free_idx)])
    else $error("granted slot not marked occupied");

endmodule
